### src/bes_pkg.sv
// Shared types and constants of the batch exchange sorter.
package bes_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 2;

    // Sort mode codes; any other code passes the batch through in arrival order.
    localparam logic [MODE_W-1:0] MODE_ASC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DESC = 2'd1;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,
        S_ROWST = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_WB    = 8'b0001_0000,
        S_ORD   = 8'b0010_0000,
        S_OWAIT = 8'b0100_0000,
        S_OSEND = 8'b1000_0000
    } state_t;

    // Control of the shared compare unit.
    typedef struct packed {
        logic descending;
        logic same_slot;
    } cmp_ctrl_t;

endpackage

### src/bes_ifs.sv
// Channel interfaces of the batch exchange sorter: input items, results, mode writes.
interface bes_item_if
    import bes_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] element_value;
    logic                     batch_end;

    modport source (output valid, output element_value, output batch_end, input ready);
    modport sink   (input valid, input element_value, input batch_end, output ready);
endinterface

interface bes_result_if
    import bes_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_flag;
    logic                     overflow_seen;

    modport source (output valid, output sorted_value, output final_flag,
                    output overflow_seen, input ready);
    modport sink   (input valid, input sorted_value, input final_flag,
                    input overflow_seen, output ready);
endinterface

interface bes_cfg_if
    import bes_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] sort_mode;

    modport source (output valid, output sort_mode, input ready);
    modport sink   (input valid, input sort_mode, output ready);
endinterface

### src/batch_exchange_sorter_unit.sv
// Top level of the batch exchange sorter: load sequencer, sort sequencer and output stage.
//
// The block collects signed 32-bit values, one per transfer on the item channel, into
// an on-chip store of MAX_ITEMS words until a transfer carries batch_end. Values that
// arrive while the store is full are dropped, and every result of that batch then shows
// overflow_seen. The batch is then sorted in place by an all-pairs exchange sort that
// uses a single signed comparator and the store's one read and one write port: the
// element of row i is held in a register while every slot j is read, compared and, when
// out of order, swapped. Sort mode 0 gives ascending order, 1 descending order, and any
// other code the original arrival order. Results leave one per transfer, the last one
// marked with final_flag. The item channel is ready only while a batch is being loaded,
// one value per cycle. The sort is skipped in pass-through mode, and its pace is set by
// the single comparator and the store's single read port. Each result is read from the
// store into an output register before it is offered, and a stall on the result side
// holds emission. The mode register may be written at any time the block is idle; its
// channel is always ready.
module batch_exchange_sorter_unit
    import bes_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    bes_item_if.sink         items,
    bes_result_if.source     results,
    bes_cfg_if.sink          mode_cfg
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     dropped_reg, dropped_next;
    logic [MODE_W-1:0]        mode_reg;
    logic [AW-1:0]            i_reg, i_next;
    logic [AW-1:0]            j_reg, j_next;
    logic [AW-1:0]            k_reg, k_next;
    logic signed [DATA_W-1:0] held_reg, held_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic                     out_final_reg, out_final_next;

    // Store ports.
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic [CW-1:0]            count_m1;
    logic [AW-1:0]            last_idx;
    cmp_ctrl_t                cmp_ctrl;
    logic                     swap;

    bes_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmp_ctrl.descending = (mode_reg == MODE_DESC);
    assign cmp_ctrl.same_slot  = (j_reg == i_reg);

    bes_cmp u_cmp (
        .ctrl        (cmp_ctrl),
        .held_value  (held_reg),
        .probe_value ($signed(ram_rdata)),
        .swap        (swap)
    );

    // Index of the last element of the batch; the batch always holds at least one.
    assign count_m1 = count_reg - CW'(1);
    assign last_idx = count_m1[AW-1:0];

    assign items.ready           = (state_reg == S_LOAD);
    assign mode_cfg.ready        = 1'b1;
    assign results.valid         = out_valid_reg;
    assign results.sorted_value  = out_value_reg;
    assign results.final_flag    = out_final_reg;
    assign results.overflow_seen = dropped_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = held_reg;
        ram_raddr      = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (items.valid)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = items.element_value;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (items.batch_end)
                    begin
                        i_next = '0;
                        if (mode_reg == MODE_ASC || mode_reg == MODE_DESC)
                        begin
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            state_next = S_ORD;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                ram_raddr  = i_reg;
                state_next = S_ROWST;
            end

            S_ROWST:
            begin
                // Row element arrives; start probing from slot zero.
                held_next  = $signed(ram_rdata);
                ram_raddr  = '0;
                j_next     = '0;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (swap)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    ram_wdata = held_reg;
                    held_next = $signed(ram_rdata);
                end
                if (j_reg == last_idx)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    j_next    = j_reg + AW'(1);
                    ram_raddr = j_reg + AW'(1);
                end
            end

            S_WB:
            begin
                // The held element goes back to its row slot.
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = held_reg;
                if (i_reg == last_idx)
                begin
                    state_next = S_ORD;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    ram_raddr  = i_reg + AW'(1);
                    state_next = S_ROWST;
                end
            end

            S_ORD:
            begin
                ram_raddr  = '0;
                k_next     = '0;
                state_next = S_OWAIT;
            end

            S_OWAIT:
            begin
                out_value_next = $signed(ram_rdata);
                out_valid_next = 1'b1;
                out_final_next = (k_reg == last_idx);
                state_next     = S_OSEND;
            end

            S_OSEND:
            begin
                // Keep the next slot on the read port so it is ready after the transfer.
                ram_raddr = k_reg + AW'(1);
                if (results.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_final_reg)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = S_OWAIT;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            mode_reg      <= MODE_ASC;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (mode_cfg.valid)
            begin
                mode_reg <= mode_cfg.sort_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        out_value_reg <= out_value_next;
        out_final_reg <= out_final_next;
    end

endmodule

### src/bes_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/bes_cmp.sv
// Shared compare unit: decides whether the held element and the probed element swap.
module bes_cmp
    import bes_pkg::*;
(
    input  cmp_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] held_value,
    input  logic signed [DATA_W-1:0] probe_value,
    output logic                     swap
);

    logic less;
    logic greater;

    assign less    = held_value < probe_value;
    assign greater = held_value > probe_value;

    // An element never swaps with its own slot; the slot in memory is stale then.
    assign swap = !ctrl.same_slot && (ctrl.descending ? greater : less);

endmodule
